@@ rtl/core/cdq_pkg.sv @@
// Package for the circular deque: request op codes, result status codes
// and the fixed field widths of the request and response streams.
// No dependencies.
package cdq_pkg;

   // Field widths of the stream payloads.
   localparam int OpWidth     = 3;
   localparam int ValueWidth  = 32;
   localparam int StatusWidth = 2;
   localparam int CapWidth    = 9;
   localparam int ReqWidth    = 40;
   localparam int RspWidth    = 72;

   // Reset value of the capacity register.
   localparam logic [CapWidth-1:0] CapReset = 9'd256;

   // Request op codes.
   localparam logic [OpWidth-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OpWidth-1:0] OP_PUSH_REAR  = 3'd1;
   localparam logic [OpWidth-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OpWidth-1:0] OP_POP_REAR   = 3'd3;
   localparam logic [OpWidth-1:0] OP_PEEK       = 3'd4;

   // Result status codes.
   localparam logic [StatusWidth-1:0] ST_OK        = 2'd0;
   localparam logic [StatusWidth-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [StatusWidth-1:0] ST_UNDERFLOW = 2'd2;

   typedef logic [ValueWidth-1:0] value_type;

endpackage

@@ rtl/core/cdq_store.sv @@
// Entry storage of the circular deque: one write port and two read ports
// with registered read data. Depends on cdq_pkg for the value type.
module cdq_store
   import cdq_pkg::*;
#(
   parameter int DEPTH = 256,
   localparam int IW = $clog2(DEPTH)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IW-1:0]   wr_addr,
   input  value_type       wr_data,
   input  logic            rd_en,
   input  logic [IW-1:0]   rd_addr_a,
   input  logic [IW-1:0]   rd_addr_b,
   output value_type       rd_data_a,
   output value_type       rd_data_b
);

   value_type mem [DEPTH];
   value_type rd_a_ff;
   value_type rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Two read ports; read data is registered, loaded from the addresses when rd_en is high.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/core/circular_deque_top.sv @@
// Top level of the circular deque: request decode, pointer and flag update,
// capacity register and the registered response stage.
// Depends on cdq_pkg and cdq_store.
//
// Flow: a taken request is held in the op, value and store read registers, then
// executes into the response register once the response slot is free; no new
// request is taken until the previous one has executed.
// Reset: pointers go to entry 0, the deque is empty, capacity is 256; the
// entry store is not cleared and needs no clearing pass.
module circular_deque_top
   import cdq_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request stream.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ReqWidth-1:0]  req_tdata,   // [2:0] op, [34:3] push_value, rest zero
   // Response stream.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RspWidth-1:0]  rsp_tdata,   // [1:0] status, [33:2] first_value,
                                             // [65:34] last_value, [66] is_full,
                                             // [67] is_empty, rest zero
   // Capacity register write.
   input  logic                 csr_wr_en,
   input  logic [CapWidth-1:0]  csr_wr_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int DW = $clog2(DEPTH + 1);
   localparam int CW = (DW > CapWidth) ? DW : CapWidth;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                  state_ff, state_in;
   logic [CapWidth-1:0]   capacity_ff;
   logic [IW-1:0]         head_ff, head_in;
   logic [IW-1:0]         tail_ff, tail_in;
   logic                  empty_ff, empty_in;
   logic [OpWidth-1:0]    op_ff;
   value_type             value_ff;
   logic                  rsp_valid_ff;
   logic [RspWidth-1:0]   rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  exec_go;
   logic [CW-1:0]         eff_cap;
   value_type             rd_head;
   value_type             rd_tail;
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic                  full_now;
   logic                  full_after;
   logic [StatusWidth-1:0] status;
   value_type             first_value;
   value_type             last_value;

   // Index increment with wrap at the capacity.
   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] cap);
      logic [CW:0] nxt;
      nxt = {{(CW + 1 - IW){1'b0}}, idx} + {{CW{1'b0}}, 1'b1};
      if (nxt >= {1'b0, cap}) begin
         return '0;
      end
      return nxt[IW-1:0];
   endfunction

   // Index decrement with wrap to the last used entry.
   function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] cap);
      logic [CW-1:0] prev;
      prev = cap - {{(CW - 1){1'b0}}, 1'b1};
      if (idx == '0) begin
         return prev[IW-1:0];
      end
      return idx - {{(IW - 1){1'b0}}, 1'b1};
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign exec_go    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   // Capacity clamped to the range 1 to DEPTH.
   always_comb begin
      eff_cap = {{(CW - CapWidth){1'b0}}, capacity_ff};
      if (eff_cap == '0) begin
         eff_cap = {{(CW - 1){1'b0}}, 1'b1};
      end
      if (eff_cap > CW'(DEPTH)) begin
         eff_cap = CW'(DEPTH);
      end
   end

   // Entry store, read at both ends when a request is taken.
   cdq_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (value_ff),
      .rd_en     (req_accept),
      .rd_addr_a (head_ff),
      .rd_addr_b (tail_ff),
      .rd_data_a (rd_head),
      .rd_data_b (rd_tail)
   );

   assign full_now = !empty_ff && (head_ff == wrap_inc(tail_ff, eff_cap));

   // Request execution: status, values, pointer and flag updates.
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      empty_in    = empty_ff;
      status      = ST_OK;
      first_value = '0;
      last_value  = '0;
      wr_en       = 1'b0;
      wr_addr     = head_ff;
      case (op_ff)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (full_now) begin
               status = ST_OVERFLOW;
            end else if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
               wr_en    = exec_go;
               wr_addr  = '0;
            end else if (op_ff == OP_PUSH_FRONT) begin
               head_in = wrap_dec(head_ff, eff_cap);
               wr_en   = exec_go;
               wr_addr = head_in;
            end else begin
               tail_in = wrap_inc(tail_ff, eff_cap);
               wr_en   = exec_go;
               wr_addr = tail_in;
            end
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (empty_ff) begin
               status = ST_UNDERFLOW;
            end else begin
               first_value = (op_ff == OP_POP_FRONT) ? rd_head : rd_tail;
               if (head_ff == tail_ff) begin
                  empty_in = 1'b1;
               end else if (op_ff == OP_POP_FRONT) begin
                  head_in = wrap_inc(head_ff, eff_cap);
               end else begin
                  tail_in = wrap_dec(tail_ff, eff_cap);
               end
            end
         end
         OP_PEEK: begin
            if (empty_ff) begin
               status = ST_UNDERFLOW;
            end else begin
               first_value = rd_head;
               last_value  = rd_tail;
            end
         end
         default: begin
         end
      endcase
   end

   assign full_after = !empty_in && (head_in == wrap_inc(tail_in, eff_cap));

   assign rsp_data_in = {4'b0, empty_in, full_after, last_value, first_value, status};

   // Sequencer: take a request, then execute it once the response slot frees.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         capacity_ff  <= CapReset;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (exec_go) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            empty_ff <= empty_in;
         end
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: request fields and the response word.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_tdata[OpWidth-1:0];
         value_ff <= req_tdata[OpWidth+ValueWidth-1:OpWidth];
      end
      if (exec_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ bench/circular_deque_top_tb.sv @@
// Self-checking bench for circular_deque_top: drives push, pop and peek requests,
// predicts each response in a scoreboard class and checks the response stream.
// Depends on cdq_pkg and the circular_deque_top RTL.
module circular_deque_top_tb;
   import cdq_pkg::*;

   localparam int Depth = 256;
   // Op codes above OP_PEEK have no meaning; the top one bounds that range.
   localparam logic [OpWidth-1:0] OpLast = '1;

   typedef struct {
      logic [StatusWidth-1:0] status;
      value_type              first;
      value_type              last;
      logic                   full;
      logic                   empty;
   } deque_result_type;

   // Predicts the deque and checks the response stream against its predictions.
   class deque_scoreboard;
      value_type           slots [Depth];
      int unsigned         head_at;
      int unsigned         tail_at;
      bit                  no_entries;
      logic [CapWidth-1:0] capacity;
      deque_result_type    awaited [$];
      int unsigned         errors;
      int unsigned         checked;

      function new();
         foreach (slots[i]) slots[i] = '0;
         head_at    = 0;
         tail_at    = 0;
         no_entries = 1'b1;
         capacity   = CapReset;
         errors     = 0;
         checked    = 0;
      endfunction

      // Capacity as the block uses it: zero acts as one, oversize as the depth.
      function int unsigned used_cap();
         if (capacity == 0) return 1;
         if (capacity > Depth) return Depth;
         return 32'(capacity);
      endfunction

      function int unsigned next_slot(int unsigned i);
         return (i + 1 >= used_cap()) ? 0 : i + 1;
      endfunction

      function int unsigned prev_slot(int unsigned i);
         return (i == 0) ? used_cap() - 1 : i - 1;
      endfunction

      function bit at_full();
         return !no_entries && head_at == next_slot(tail_at);
      endfunction

      // Apply one accepted request and queue the response it must produce.
      function void note_request(logic [OpWidth-1:0] op, value_type v);
         deque_result_type r;
         r.status = ST_OK;
         r.first  = '0;
         r.last   = '0;
         case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
               if (at_full()) begin
                  r.status = ST_OVERFLOW;
               end else if (no_entries) begin
                  // The first entry always lands in slot zero.
                  head_at    = 0;
                  tail_at    = 0;
                  no_entries = 1'b0;
                  slots[0]   = v;
               end else if (op == OP_PUSH_FRONT) begin
                  head_at = prev_slot(head_at);
                  slots[head_at] = v;
               end else begin
                  tail_at = next_slot(tail_at);
                  slots[tail_at] = v;
               end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
               if (no_entries) begin
                  r.status = ST_UNDERFLOW;
               end else begin
                  r.first = slots[op == OP_POP_FRONT ? head_at : tail_at];
                  // Popping the last entry leaves the pointers where they are.
                  if (head_at == tail_at) no_entries = 1'b1;
                  else if (op == OP_POP_FRONT) head_at = next_slot(head_at);
                  else tail_at = prev_slot(tail_at);
               end
            end
            OP_PEEK: begin
               if (no_entries) begin
                  r.status = ST_UNDERFLOW;
               end else begin
                  r.first = slots[head_at];
                  r.last  = slots[tail_at];
               end
            end
            default: ;
         endcase
         r.full  = at_full();
         r.empty = no_entries;
         awaited.push_back(r);
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 40) $display("mismatch: %s", what);
      endtask

      task compare_field(string name, logic [ValueWidth-1:0] got, logic [ValueWidth-1:0] want);
         if (got !== want)
            report_mismatch($sformatf("response %0d %s got %h expected %h",
                                      checked, name, got, want));
      endtask

      // Check one accepted response against the oldest prediction.
      task check_response(logic [RspWidth-1:0] d);
         deque_result_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with nothing outstanding", checked));
            checked++;
            return;
         end
         want = awaited.pop_front();
         compare_field("status", 32'(d[1:0]), 32'(want.status));
         compare_field("first_value", d[33:2], want.first);
         compare_field("last_value", d[65:34], want.last);
         compare_field("is_full", 32'(d[66]), 32'(want.full));
         compare_field("is_empty", 32'(d[67]), 32'(want.empty));
         checked++;
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqWidth-1:0] req_tdata;   // [2:0] op, [34:3] push_value, rest zero
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspWidth-1:0] rsp_tdata;   // [1:0] status, [33:2] first_value, [65:34] last_value,
                                     // [66] is_full, [67] is_empty, rest zero
   logic                csr_wr_en;
   logic [CapWidth-1:0] csr_wr_data;

   bit              idle_on;
   deque_scoreboard sb;

   circular_deque_top #(.DEPTH(Depth)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Send one request, with an optional idle burst ahead of it.
   task automatic send_request(logic [OpWidth-1:0] op, value_type v);
      logic [ReqWidth-1:0] word;
      if (idle_on && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(15, 1)) @(posedge clock);
      end
      word = '0;
      word[OpWidth-1:0] = op;
      word[OpWidth +: ValueWidth] = v;
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, v);
   endtask

   task automatic send_random(int unsigned push_pct);
      logic [OpWidth-1:0] op;
      int unsigned pick;
      pick = $urandom_range(9);
      if ($urandom_range(99) < push_pct) op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      else if (pick < 4) op = OP_POP_FRONT;
      else if (pick < 7) op = OP_POP_REAR;
      else if (pick < 9) op = OP_PEEK;
      else op = OpWidth'($urandom_range(OpLast, OP_PEEK + 1));
      send_request(op, $urandom());
   endtask

   // Pop until the deque is empty so that a capacity change is always safe.
   task automatic drain();
      while (!sb.no_entries)
         send_request($urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR, $urandom());
   endtask

   // Stop requesting and wait for every outstanding response plus the pipeline depth.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CapWidth-1:0] c);
      wait_idle();
      csr_wr_data <= c;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.capacity = c;
   endtask

   task automatic run_phase(logic [CapWidth-1:0] c, int n, int unsigned push_pct, bit calm);
      drain();
      write_capacity(c);
      idle_on = !calm && ($urandom_range(3) != 0);
      repeat (n) send_random(push_pct);
   endtask

   // Response side: check each accepted response, then choose the next ready value.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(7) == 0) begin
            stall_left = $urandom_range(15, 1) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Main sequence: directed corner cases, then random phases across capacities.
   initial begin
      sb          = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      idle_on     = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Underflow and an unknown op on the empty deque after reset.
      send_request(OP_POP_FRONT, 32'h0);
      send_request(OP_POP_REAR, 32'h0);
      send_request(OP_PEEK, 32'h0);
      send_request(OpLast, 32'hFFFF_FFFF);
      // Extreme values through both ends, then drained from both ends.
      send_request(OP_PUSH_FRONT, 32'h8000_0000);
      send_request(OP_PUSH_REAR, 32'h7FFF_FFFF);
      send_request(OP_PUSH_FRONT, 32'h0000_0000);
      send_request(OP_PUSH_REAR, 32'hFFFF_FFFF);
      send_request(OP_PEEK, 32'h0);
      send_request(OP_POP_REAR, 32'h0);
      send_request(OP_POP_FRONT, 32'h0);
      send_request(OP_POP_REAR, 32'h0);
      send_request(OP_POP_FRONT, 32'h0);
      send_request(OP_POP_FRONT, 32'h0);

      // A single-entry deque fills at once and overflows on both ends.
      write_capacity(9'd1);
      send_request(OP_PUSH_REAR, 32'h1234_5678);
      send_request(OP_PUSH_FRONT, 32'hDEAD_BEEF);
      send_request(OP_PUSH_REAR, 32'hCAFE_F00D);
      send_request(OP_PEEK, 32'h0);
      send_request(OP_POP_REAR, 32'h0);

      // Capacity raised while entries are held; the contents do not wrap.
      write_capacity(9'd3);
      send_request(OP_PUSH_REAR, 32'h0000_0011);
      send_request(OP_PUSH_REAR, 32'h0000_0022);
      write_capacity(9'd6);
      send_request(OP_PUSH_REAR, 32'h0000_0033);
      send_request(OP_PUSH_FRONT, 32'h0000_0044);
      send_request(OP_PEEK, 32'h0);
      send_request(OP_POP_FRONT, 32'h0);

      // Random phases; out-of-range capacities and a full-depth fill included.
      run_phase(9'd1, 15, 50, 1'b0);
      run_phase(9'd2, 15, 50, 1'b0);
      run_phase(9'd5, 25, 60, 1'b0);
      run_phase(9'd5, 15, 30, 1'b0);
      run_phase(9'd0, 10, 50, 1'b0);
      run_phase(9'd3, 20, 50, 1'b0);
      run_phase(9'd511, 280, 97, 1'b0);
      run_phase(9'd17, 20, 50, 1'b0);
      run_phase(9'd256, 25, 40, 1'b1);
      drain();

      wait_idle();
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
